FILE: hw/rtl/tslp_pkg.sv
// Shared types, codes and helper functions of the text symbol line parser.
`default_nettype none

package tslp_pkg;

	localparam int unsigned RqDepth = 4;

	localparam logic [7:0] ChSpace = 8'd32;
	localparam logic [7:0] ChDel   = 8'd127;
	localparam logic [7:0] ChZero  = 8'd48;
	localparam logic [7:0] ChNine  = 8'd57;
	localparam logic [7:0] ChLowA  = 8'd97;
	localparam logic [7:0] ChLowF  = 8'd102;
	localparam logic [7:0] ChUpA   = 8'd65;
	localparam logic [7:0] ChUpF   = 8'd70;
	localparam logic [7:0] HexTen  = 8'd10;

	typedef enum logic [1:0] {
		KIND_NAME = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_NAME   = 5'b00010,
		MODE_SPACES = 5'b00100,
		MODE_DIGITS = 5'b01000,
		MODE_DROP   = 5'b10000
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_byte;
		logic [31:0] addr;
		logic        run_end;
	} result_t;

	typedef struct packed {
		logic [1:0]  count;
		result_t     res0;
		result_t     res1;
		mode_t       mode_next;
		logic [31:0] acc_next;
	} parse_out_t;

	// Returns {is_hex, digit value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			hex_digit = 5'd0;
			if (c >= ChZero && c <= ChNine) begin
				d = c - ChZero;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= ChLowA && c <= ChLowF) begin
				d = c - ChLowA + HexTen;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= ChUpA && c <= ChUpF) begin
				d = c - ChUpA + HexTen;
				hex_digit = {1'b1, d[3:0]};
			end
		end
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tslp_parse.sv
// Per-byte record parsing: next mode, next address and up to two results.
`default_nettype none

module tslp_parse
	import tslp_pkg::*;
(
	input  mode_t       mode,
	input  logic [31:0] acc,
	input  logic [7:0]  byte_in,
	input  logic        last,
	output parse_out_t  po
);

	logic        printable;
	logic [4:0]  hx;
	logic [31:0] acc_shift;
	result_t     r_name;
	result_t     r_err;
	result_t     r_done;
	result_t     r_done_new;

	always_comb begin
		printable  = (byte_in > ChSpace) && (byte_in < ChDel);
		hx         = hex_digit(byte_in);
		acc_shift  = {acc[27:0], hx[3:0]};
		r_name     = '{kind: KIND_NAME, name_byte: byte_in, addr: 32'd0, run_end: 1'b0};
		r_err      = '{kind: KIND_ERR, name_byte: 8'd0, addr: 32'd0, run_end: 1'b0};
		r_done     = '{kind: KIND_DONE, name_byte: 8'd0, addr: acc, run_end: 1'b0};
		r_done_new = '{kind: KIND_DONE, name_byte: 8'd0, addr: acc_shift, run_end: 1'b0};

		po.count     = 2'd0;
		po.res0      = r_err;
		po.res1      = r_err;
		po.mode_next = mode;
		po.acc_next  = acc;

		case (mode)
			MODE_NAME: begin
				if (printable) begin
					po.res0  = r_name;
					po.count = last ? 2'd2 : 2'd1;
				end else if (byte_in == ChSpace) begin
					po.mode_next = MODE_SPACES;
					po.res0      = r_done;
					po.count     = last ? 2'd1 : 2'd0;
				end else begin
					po.count     = 2'd1;
					po.mode_next = MODE_DROP;
				end
			end
			MODE_SPACES, MODE_DIGITS: begin
				if (byte_in == ChSpace && mode == MODE_SPACES) begin
					po.res0  = r_done;
					po.count = last ? 2'd1 : 2'd0;
				end else if (hx[4]) begin
					po.acc_next  = acc_shift;
					po.mode_next = MODE_DIGITS;
					po.res0      = r_done_new;
					po.count     = last ? 2'd1 : 2'd0;
				end else if (byte_in < ChSpace) begin
					po.res0      = r_done;
					po.count     = 2'd1;
					po.mode_next = MODE_IDLE;
					po.acc_next  = 32'd0;
				end else begin
					po.count     = 2'd1;
					po.mode_next = MODE_DROP;
				end
			end
			MODE_DROP: begin
				po.count = 2'd0;
			end
			default: begin
				if (byte_in <= ChSpace) begin
					po.mode_next = MODE_IDLE;
				end else if (printable) begin
					po.acc_next  = 32'd0;
					po.res0      = r_name;
					po.mode_next = MODE_NAME;
					po.count     = last ? 2'd2 : 2'd1;
				end else begin
					po.count     = 2'd1;
					po.mode_next = MODE_DROP;
				end
			end
		endcase

		// The last byte of a file always leaves the parser clean for the next file.
		if (last) begin
			po.mode_next = MODE_IDLE;
			po.acc_next  = 32'd0;
		end

		if (po.count == 2'd2) begin
			po.res1.run_end = 1'b1;
		end else begin
			po.res0.run_end = 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tslp_rq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while pop is high and it is not empty.
`default_nettype none

module tslp_rq
	import tslp_pkg::*;
#(
	parameter int unsigned DEPTH = RqDepth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   push_n,
	input  result_t                      wdata0,
	input  result_t                      wdata1,
	input  logic                         pop,
	output result_t                      head,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

	result_t       mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wr_nxt1;
	logic [AW-1:0] wr_nxt2;
	logic          do_pop;

	always_comb begin
		wr_nxt1 = (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
		wr_nxt2 = (wr_nxt1 == LastIdx) ? '0 : wr_nxt1 + AW'(1);
		do_pop  = pop && (count_q != '0);
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= wdata0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_nxt1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push_n)
				2'd1:    wr_q <= wr_nxt1;
				2'd2:    wr_q <= wr_nxt2;
				default: wr_q <= wr_q;
			endcase
			if (do_pop) begin
				rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
			end
			count_q <= count_q + CW'(push_n) - CW'(do_pop);
		end
	end

	assign head      = mem_q[rd_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/text_symbol_line_parser.sv
// Top level of the text symbol line parser: input stage, parser state and result queue.
`default_nettype none

// The parser takes one byte of a text symbol file per word on the input
// channel and returns name bytes, record-complete words carrying the 32-bit
// hex address, and format errors on the output channel. A byte is captured
// into an input register; once the queue has room, the parser logic updates
// the record state and writes up to two results into a small result queue,
// from which one result word leaves per cycle while the output side takes
// words. The block accepts one byte per clock cycle as long as the queue has
// room for two results, which is set by the queue depth parameter and by how
// quickly the output side takes words. A byte that ends a file while inside
// a name yields two results, so a long stream of such bytes is held back by
// the single output port. After a format error, bytes are swallowed without
// results up to and including the byte marked as the last of the file.

module text_symbol_line_parser
	import tslp_pkg::*;
#(
	parameter int unsigned RQ_DEPTH = RqDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  name_byte,
	output logic [31:0] symbol_address,
	output logic        run_end
);

	localparam int unsigned CW = $clog2(RQ_DEPTH + 1);
	localparam logic [CW-1:0] RoomLimit = CW'(RQ_DEPTH - 2);

	// Input stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        final_s1;

	// Record state.
	mode_t       mode_q;
	logic [31:0] acc_q;

	parse_out_t    po;
	result_t       head;
	logic          rq_not_empty;
	logic [CW-1:0] rq_count;
	logic          advance;
	logic [1:0]    push_n;

	// The parser only consumes the staged byte when the queue can absorb
	// the worst case of two results, judged from registered count alone.
	assign advance  = valid_s1 && (rq_count <= RoomLimit);
	assign in_ready = !valid_s1 || (rq_count <= RoomLimit);
	assign push_n   = advance ? po.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= byte_value;
			final_s1 <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= 32'd0;
		end else if (advance) begin
			mode_q <= po.mode_next;
			acc_q  <= po.acc_next;
		end
	end

	tslp_parse u_parse (
		.mode    (mode_q),
		.acc     (acc_q),
		.byte_in (byte_s1),
		.last    (final_s1),
		.po      (po)
	);

	tslp_rq #(
		.DEPTH (RQ_DEPTH)
	) u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.wdata0    (po.res0),
		.wdata1    (po.res1),
		.pop       (out_ready),
		.head      (head),
		.not_empty (rq_not_empty),
		.count     (rq_count)
	);

	assign out_valid      = rq_not_empty;
	assign kind           = head.kind;
	assign name_byte      = head.name_byte;
	assign symbol_address = head.addr;
	assign run_end        = head.run_end;

	// The queue never holds more results than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n) rq_count <= CW'(RQ_DEPTH))
		else $error("result queue overflow");

	// A staged byte that cannot advance is kept for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(final_s1)))
		else $error("staged byte lost while stalled");

	// The last byte of a file returns the parser to idle with a clear address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && final_s1) |=> (mode_q == MODE_IDLE && acc_q == 32'd0))
		else $error("parser not reset at end of file");

	// Nothing is pushed without a staged byte being consumed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rq_count > $past(rq_count)) |-> $past(advance))
		else $error("result pushed without a byte");

endmodule

`default_nettype wire

FILE: dv/text_symbol_line_parser_tb.sv
// Self-checking testbench of the text symbol line parser: directed table, random files, scoreboard.

module text_symbol_line_parser_tb
	import tslp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Rough bound on the run: about 700 bytes, two words each at worst, slow
	// receiver, plus one long hold-off. This is many times that.
	localparam int CYCLE_LIMIT = 200000;
	// Least number of random bytes offered, swallowed ones included.
	localparam int RANDOM_BYTES = 650;
	// Length of the one long output hold-off, in cycles.
	localparam int HOLD_CYCLES = 60;

	localparam result_t NO_WORD = '0;
	localparam result_t ERR_LAST = '{KIND_ERR, 8'h00, 32'h0, 1'b1};
	localparam result_t DONE_ZERO_LAST = '{KIND_DONE, 8'h00, 32'h0, 1'b1};

	// One row of the directed table. Where typed is set, count words w0/w1
	// are the expected output; otherwise the parser model supplies it.
	typedef struct packed {
		logic [7:0] data;
		logic       eof;
		logic       typed;
		logic [1:0] count;
		result_t    w0;
		result_t    w1;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = 8'h00;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  name_byte;
	logic [31:0] symbol_address;
	logic        run_end;

	// Model state of the parser, kept in step with every accepted byte.
	mode_t       pmode;
	logic [31:0] pacc;

	// Words still owed by the block, oldest first.
	result_t     expected_words [$];

	int fail_count = 0;
	int cycle_count = 0;
	// Idle mix: 0 sender light / receiver heavy, 1 the reverse, 2 no idling.
	int phase = 0;
	int live_count = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int names_seen = 0;
	int records_seen = 0;
	int errors_seen = 0;

	text_symbol_line_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_value    (byte_value),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.name_byte     (name_byte),
		.symbol_address(symbol_address),
		.run_end       (run_end)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic result_t make_word(input kind_t k, input logic [7:0] nb,
			input logic [31:0] a);
		result_t w;
		w.kind = k;
		w.name_byte = nb;
		w.addr = a;
		w.run_end = 1'b0;
		return w;
	endfunction

	function automatic result_t name_word(input logic [7:0] c, input logic last_one);
		result_t w;
		w = make_word(KIND_NAME, c, '0);
		w.run_end = last_one;
		return w;
	endfunction

	// {is a hex digit, its value}. Letters in either case have the digit's
	// low nibble one to six, so adding nine gives ten to fifteen.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b1, c[3:0]};
		end
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			return {1'b1, c[3:0] + 4'd9};
		end
		return 5'd0;
	endfunction

	// Advances the parser model by one byte. With keep set, the words that
	// the byte causes are queued as expectations.
	function automatic void parse_byte(input logic [7:0] c, input logic fin,
			input bit keep);
		result_t    r [2];
		int         n;
		logic       printable;
		logic [4:0] hv;
		n = 0;
		printable = (c > ChSpace) && (c < ChDel);
		hv = hex_nibble(c);
		case (pmode)
			MODE_NAME: begin
				if (printable) begin
					r[n] = make_word(KIND_NAME, c, '0);
					n++;
					// A file may not end inside a name.
					if (fin) begin
						r[n] = make_word(KIND_ERR, '0, '0);
						n++;
					end
				end else if (c == ChSpace) begin
					pmode = MODE_SPACES;
					if (fin) begin
						r[n] = make_word(KIND_DONE, '0, pacc);
						n++;
					end
				end else begin
					r[n] = make_word(KIND_ERR, '0, '0);
					n++;
					pmode = MODE_DROP;
				end
			end
			MODE_SPACES, MODE_DIGITS: begin
				if (c == ChSpace && pmode == MODE_SPACES) begin
					if (fin) begin
						r[n] = make_word(KIND_DONE, '0, pacc);
						n++;
					end
				end else if (hv[4]) begin
					// Older digits fall off the top: the address wraps.
					pacc = {pacc[27:0], hv[3:0]};
					pmode = MODE_DIGITS;
					if (fin) begin
						r[n] = make_word(KIND_DONE, '0, pacc);
						n++;
					end
				end else if (c < ChSpace) begin
					r[n] = make_word(KIND_DONE, '0, pacc);
					n++;
					pmode = MODE_IDLE;
					pacc = '0;
				end else begin
					r[n] = make_word(KIND_ERR, '0, '0);
					n++;
					pmode = MODE_DROP;
				end
			end
			MODE_DROP: ;
			default: begin
				if (c <= ChSpace) begin
					pmode = MODE_IDLE;
				end else if (printable) begin
					pacc = '0;
					r[n] = make_word(KIND_NAME, c, '0);
					n++;
					pmode = MODE_NAME;
					if (fin) begin
						r[n] = make_word(KIND_ERR, '0, '0);
						n++;
					end
				end else begin
					r[n] = make_word(KIND_ERR, '0, '0);
					n++;
					pmode = MODE_DROP;
				end
			end
		endcase
		// The last byte of a file always leaves the parser clean.
		if (fin) begin
			pmode = MODE_IDLE;
			pacc = '0;
		end
		if (n > 0) begin
			r[n - 1].run_end = 1'b1;
		end
		if (keep) begin
			for (int i = 0; i < n; i++) begin
				expected_words.push_back(r[i]);
			end
		end
	endfunction

	// Offers one byte and waits until the block takes it. Valid and payload
	// are set once and held until the handshake; the model then steps.
	task automatic offer_byte(input logic [7:0] b, input logic fin, input bit keep);
		while ($urandom_range(0, 99) < ((phase == 0) ? 11 : (phase == 1) ? 58 : 0)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		final_byte <= fin;
		do @(posedge clk); while (in_ready !== 1'b1);
		live_count++;
		bytes_sent++;
		parse_byte(b, fin, keep);
	endtask

	// Output side: checks every word taken and decides out_ready for the next
	// edge. Values are read right after the edge, before any update of it.
	initial begin : drain
		int      hold_left;
		bit      held;
		result_t want;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: word with nothing expected: kind %0d name %h addr %h end %b",
						$time, kind, name_byte, symbol_address, run_end);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					case (want.kind)
						KIND_NAME: names_seen++;
						KIND_DONE: records_seen++;
						default: errors_seen++;
					endcase
					if (kind !== want.kind) begin
						$display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
						fail_count++;
					end
					if (name_byte !== want.name_byte) begin
						$display("%0t: name_byte expected %h, got %h", $time,
							want.name_byte, name_byte);
						fail_count++;
					end
					if (symbol_address !== want.addr) begin
						$display("%0t: symbol_address expected %h, got %h", $time,
							want.addr, symbol_address);
						fail_count++;
					end
					if (run_end !== want.run_end) begin
						$display("%0t: run_end expected %b, got %b", $time,
							want.run_end, run_end);
						fail_count++;
					end
				end
			end
			// Once, when the no-idle mix starts, the receiver shuts off for a
			// long stretch while bytes keep coming, so the result queue fills
			// and the block has to drop in_ready.
			if (phase == 2 && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >=
					((phase == 0) ? 58 : (phase == 1) ? 11 : 0));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timed out with %0d words still expected", $time,
			expected_words.size());
		$display("text_symbol_line_parser_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		stim_row_t  rows [25];
		logic [7:0] file_q [$];
		logic [7:0] ch;
		int         nrec;
		int         v;
		int         cut;
		arst_n <= 1'b0;
		pmode = MODE_IDLE;
		pacc = '0;

		rows = '{
			// Filler after reset: a control byte and a space give nothing.
			'{8'h00, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
			'{8'h20, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
			// The top byte value starts a name that is bad at once, and it
			// also ends the file, which leaves the parser idle again.
			'{8'hFF, 1'b1, 1'b1, 2'd1, ERR_LAST, NO_WORD},
			// Lowest and highest name characters.
			'{8'h21, 1'b0, 1'b1, 2'd1, name_word(8'h21, 1'b1), NO_WORD},
			'{8'h7E, 1'b0, 1'b1, 2'd1, name_word(8'h7E, 1'b1), NO_WORD},
			'{8'h20, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
			// Nine digits in mixed case: the first one wraps out of the
			// 32-bit address.
			'{8'h46, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h66, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h30, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h39, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h61, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h41, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h38, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h31, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h32, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			// The highest control byte closes the record.
			'{8'h1F, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
			// End of file inside a name: the character, then an error.
			'{8'h78, 1'b1, 1'b1, 2'd2, name_word(8'h78, 1'b0), ERR_LAST},
			'{8'h6B, 1'b0, 1'b1, 2'd1, name_word(8'h6B, 1'b1), NO_WORD},
			// End of file on the space after a name: record, address zero.
			'{8'h20, 1'b1, 1'b1, 2'd1, DONE_ZERO_LAST, NO_WORD},
			'{8'h71, 1'b0, 1'b1, 2'd1, name_word(8'h71, 1'b1), NO_WORD},
			'{8'h20, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
			// End of file on a digit: the digit still goes into the address.
			'{8'h37, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{8'h7A, 1'b0, 1'b1, 2'd1, name_word(8'h7A, 1'b1), NO_WORD},
			// DEL inside a name is an error; bytes are dropped through the
			// final one.
			'{8'h7F, 1'b0, 1'b1, 2'd1, ERR_LAST, NO_WORD},
			'{8'h0A, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			offer_byte(rows[i].data, rows[i].eof, !rows[i].typed);
			if (rows[i].typed) begin
				if (rows[i].count > 0) begin
					expected_words.push_back(rows[i].w0);
				end
				if (rows[i].count > 1) begin
					expected_words.push_back(rows[i].w1);
				end
			end
		end
		files_sent = 5;
		live_count = 0;

		// Random files. Most are well-formed records with random content so
		// that all parsing states are reached; some are pure noise, some get
		// a stray byte, and some are cut short at a random point.
		while (live_count < RANDOM_BYTES) begin
			phase = (live_count < RANDOM_BYTES / 3) ? 0 :
				(live_count < 2 * RANDOM_BYTES / 3) ? 1 : 2;
			file_q.delete();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				nrec = $urandom_range(1, 4);
				repeat (nrec) begin
					repeat ($urandom_range(0, 2)) begin
						ch = ($urandom_range(0, 3) == 0) ? ChSpace : 8'($urandom_range(0, 31));
						file_q.push_back(ch);
					end
					repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(33, 126)));
					repeat ($urandom_range(1, 3)) file_q.push_back(ChSpace);
					// Now and then more than eight digits, to wrap the address.
					repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) :
							$urandom_range(0, 8)) begin
						v = $urandom_range(0, 15);
						if (v < 10) begin
							ch = ChZero + 8'(v);
						end else begin
							ch = (($urandom_range(0, 1) == 0) ? ChLowA : ChUpA) + 8'(v - 10);
						end
						file_q.push_back(ch);
					end
					file_q.push_back(8'($urandom_range(0, 31)));
				end
				foreach (file_q[i]) begin
					if ($urandom_range(0, 24) == 0) begin
						file_q[i] = 8'($urandom_range(0, 255));
					end
				end
				if ($urandom_range(0, 3) == 0) begin
					cut = $urandom_range(1, file_q.size());
					while (file_q.size() > cut) file_q.pop_back();
				end
			end
			foreach (file_q[i]) begin
				offer_byte(file_q[i], i == file_q.size() - 1, 1'b1);
			end
			files_sent++;
		end
		in_valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		// Give the block time to show any stray words.
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes in %0d files, with three idle mixes and one long output hold-off.",
			bytes_sent, files_sent);
		$display("Checked %0d name bytes, %0d completed records and %0d format errors.",
			names_seen, records_seen, errors_seen);
		if (fail_count == 0) begin
			$display("text_symbol_line_parser_tb OK");
		end else begin
			$display("text_symbol_line_parser_tb NOT OK");
		end
		$finish;
	end

endmodule
